[rtl/core/tpnfu_pkg.sv]
// Package for the timed Petri net fire unit: request/result payloads,
// operation and status codes, controller-to-datapath command and status.
// No dependencies.
package tpnfu_pkg;

	localparam logic [2:0] OP_WR_PRE    = 3'd0;
	localparam logic [2:0] OP_WR_POST   = 3'd1;
	localparam logic [2:0] OP_WR_DELAY  = 3'd2;
	localparam logic [2:0] OP_WR_STATE  = 3'd3;
	localparam logic [2:0] OP_WR_ELAPSE = 3'd4;
	localparam logic [2:0] OP_FIRE      = 3'd5;
	localparam logic [2:0] OP_COMMIT    = 3'd6;

	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_FIRED   = 2'd1;
	localparam logic [1:0] ST_NOT_EN  = 2'd2;
	localparam logic [1:0] ST_BAD     = 2'd3;

	localparam logic [3:0] CFG_PLACES = 4'd0;
	localparam logic [3:0] CFG_TRANS  = 4'd1;

	localparam logic [4:0] FIELD_CAP = 5'd16;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  place;
		logic [3:0]  transition;
		logic [7:0]  weight;
		logic [15:0] value;
		logic [23:0] wait_value;
		logic [31:0] elapsed_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  out_place;
		logic [15:0] tokens;
		logic [23:0] wait_time;
		logic [23:0] step_time;
		logic [31:0] elapsed;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       start;
		logic       exec_wr;
		logic       scan;
		logic       adv;
		logic       idx_zero;
		logic       el_calc;
		logic       emit_fire;
		logic       emit_single;
		logic       clr_run;
		logic [1:0] single_status;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       req_ok;
		logic       fail;
		logic       last_idx;
		logic       out_free;
		logic       clr_done;
	} sts_t;

endpackage

[rtl/core/tpnfu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpnfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/tpnfu_ctrl.sv]
// Controller FSM of the timed Petri net fire unit: sequences clear, writes,
// the enable/step scan and the update/emit pass. Depends on tpnfu_pkg.
module tpnfu_ctrl
	import tpnfu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic request_valid,
	output logic request_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;
	localparam logic [2:0] S_UPD    = 3'd6;
	localparam logic [2:0] S_SINGLE = 3'd7;

	logic [2:0] state_q, state_n;
	logic [1:0] rsp_q, rsp_n;

	assign request_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		rsp_n   = rsp_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_done) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (request_valid) begin
					cmd.start = 1'b1;
					state_n   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.op == OP_FIRE || sts.op == OP_COMMIT) begin
					if (sts.req_ok) begin
						state_n = S_SCAN;
					end else begin
						rsp_n   = ST_BAD;
						state_n = S_SINGLE;
					end
				end else begin
					cmd.exec_wr = sts.req_ok;
					rsp_n       = sts.req_ok ? ST_WRITTEN : ST_BAD;
					state_n     = S_SINGLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				cmd.adv  = 1'b1;
				if (sts.last_idx) state_n = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.idx_zero = 1'b1;
				state_n      = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.fail) begin
					rsp_n   = ST_NOT_EN;
					state_n = S_SINGLE;
				end else begin
					cmd.el_calc = 1'b1;
					state_n     = S_UPD;
				end
			end
			S_UPD: begin
				if (sts.out_free) begin
					cmd.emit_fire = 1'b1;
					cmd.adv       = 1'b1;
					if (sts.last_idx) state_n = S_IDLE;
				end
			end
			S_SINGLE: begin
				cmd.single_status = rsp_q;
				if (sts.out_free) begin
					cmd.emit_single = 1'b1;
					state_n         = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			rsp_q   <= ST_WRITTEN;
		end else begin
			state_q <= state_n;
			rsp_q   <= rsp_n;
		end
	end

endmodule

[rtl/core/tpnfu_dp.sv]
// Datapath of the timed Petri net fire unit: net memories, config registers,
// step accumulation, marking update and result register.
// Depends on tpnfu_pkg and tpnfu_ram.
module tpnfu_dp
	import tpnfu_pkg::*;
#(
	parameter int MAX_PLACES      = 16,
	parameter int MAX_TRANSITIONS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       request,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [4:0] cfg_data,
	output logic       result_valid,
	input  logic       result_stall,
	output res_t       result,
	input  cmd_t       cmd,
	output sts_t       sts
);

	localparam int NW   = MAX_PLACES * MAX_TRANSITIONS;
	localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int PAW  = (MAX_PLACES > 1) ? $clog2(MAX_PLACES) : 1;
	localparam int PCAP = (MAX_PLACES < 16) ? MAX_PLACES : 16;
	localparam int TCAP = (MAX_TRANSITIONS < 16) ? MAX_TRANSITIONS : 16;

	req_t        req_q;
	logic [4:0]  places_q, trans_q, np, nt;
	logic [4:0]  idx_q, rd_idx;
	logic [WAW-1:0] clr_q;
	logic        clr_place;
	logic        pl_ok, tr_ok;
	logic [23:0] step_q;
	logic [31:0] elapsed_q, el_q;
	logic [32:0] el_sum;
	logic        fail_q;
	logic        vld_s1, pwnz_s1;
	logic [23:0] need_s1, wt_s1, diff;
	res_t        out_q, out_d;
	logic        out_vld_q;

	logic [WAW-1:0] w_waddr, w_raddr;
	logic [PAW-1:0] p_raddr, mk_waddr, dl_waddr;
	logic [7:0]  pw, qw;
	logic [15:0] dl, mk;
	logic [23:0] wt;
	logic        pre_we, post_we, dl_we, mk_we;
	logic [15:0] mk_wdata;
	logic [23:0] wt_wdata;
	logic [16:0] tsum;
	logic [15:0] tok;
	logic [24:0] wsum;
	logic [23:0] wnew;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (places_q == 5'd0) np = 5'd1;
		else if (places_q > 5'(PCAP)) np = 5'(PCAP);
		else np = places_q;
		if (trans_q == 5'd0) nt = 5'd1;
		else if (trans_q > 5'(TCAP)) nt = 5'(TCAP);
		else nt = trans_q;
	end

	assign pl_ok = {1'b0, req_q.place} < np;
	assign tr_ok = {1'b0, req_q.transition} < nt;

	always_comb begin
		unique case (req_q.operation)
			OP_WR_PRE, OP_WR_POST:     sts.req_ok = pl_ok && tr_ok;
			OP_WR_DELAY, OP_WR_STATE:  sts.req_ok = pl_ok;
			OP_WR_ELAPSE:              sts.req_ok = 1'b1;
			OP_FIRE, OP_COMMIT:        sts.req_ok = tr_ok;
			default:                   sts.req_ok = 1'b0;
		endcase
	end

	assign sts.op       = req_q.operation;
	assign sts.fail     = fail_q;
	assign sts.last_idx = (idx_q == np - 5'd1);
	assign sts.out_free = !out_vld_q || !result_stall;
	assign sts.clr_done = (clr_q == WAW'(NW - 1));

	always_comb begin
		priority if (cmd.adv) rd_idx = idx_q + 5'd1;
		else if (cmd.idx_zero) rd_idx = 5'd0;
		else rd_idx = idx_q;
	end

	assign w_raddr   = WAW'(32'(rd_idx) * MAX_TRANSITIONS + 32'(req_q.transition));
	assign w_waddr   = WAW'(32'(req_q.place) * MAX_TRANSITIONS + 32'(req_q.transition));
	assign p_raddr   = PAW'(rd_idx);
	assign clr_place = cmd.clr_run && (32'(clr_q) < MAX_PLACES);

	assign pre_we  = cmd.clr_run || (cmd.exec_wr && req_q.operation == OP_WR_PRE);
	assign post_we = cmd.clr_run || (cmd.exec_wr && req_q.operation == OP_WR_POST);
	assign dl_we   = clr_place || (cmd.exec_wr && req_q.operation == OP_WR_DELAY);
	assign mk_we   = clr_place || (cmd.exec_wr && req_q.operation == OP_WR_STATE)
		|| (cmd.emit_fire && req_q.operation == OP_COMMIT);
	assign dl_waddr = cmd.clr_run ? PAW'(clr_q) : PAW'(req_q.place);

	always_comb begin
		priority if (cmd.clr_run) begin
			mk_waddr = PAW'(clr_q);
			mk_wdata = '0;
			wt_wdata = '0;
		end else if (cmd.emit_fire) begin
			mk_waddr = PAW'(idx_q);
			mk_wdata = tok;
			wt_wdata = wnew;
		end else begin
			mk_waddr = PAW'(req_q.place);
			mk_wdata = req_q.value;
			wt_wdata = req_q.wait_value;
		end
	end

	tpnfu_ram #(.WIDTH(8), .DEPTH(NW)) u_pre (
		.clk(clk), .we(pre_we), .waddr(cmd.clr_run ? clr_q : w_waddr),
		.wdata(cmd.clr_run ? 8'd0 : req_q.weight), .raddr(w_raddr), .rdata(pw)
	);

	tpnfu_ram #(.WIDTH(8), .DEPTH(NW)) u_post (
		.clk(clk), .we(post_we), .waddr(cmd.clr_run ? clr_q : w_waddr),
		.wdata(cmd.clr_run ? 8'd0 : req_q.weight), .raddr(w_raddr), .rdata(qw)
	);

	tpnfu_ram #(.WIDTH(16), .DEPTH(MAX_PLACES)) u_delay (
		.clk(clk), .we(dl_we), .waddr(dl_waddr),
		.wdata(cmd.clr_run ? 16'd0 : req_q.value), .raddr(p_raddr), .rdata(dl)
	);

	tpnfu_ram #(.WIDTH(16), .DEPTH(MAX_PLACES)) u_mark (
		.clk(clk), .we(mk_we), .waddr(mk_waddr),
		.wdata(mk_wdata), .raddr(p_raddr), .rdata(mk)
	);

	tpnfu_ram #(.WIDTH(24), .DEPTH(MAX_PLACES)) u_wait (
		.clk(clk), .we(mk_we), .waddr(mk_waddr),
		.wdata(wt_wdata), .raddr(p_raddr), .rdata(wt)
	);

	// new marking of the place at idx_q
	assign tsum = {1'b0, mk} - {9'd0, pw} + {9'd0, qw};
	assign tok  = tsum[16] ? 16'hFFFF : tsum[15:0];
	assign wsum = {1'b0, wt} + {1'b0, step_q};
	assign wnew = (dl == 16'd0 || tok == 16'd0 || mk == 16'd0) ? 24'd0 :
		(wsum[24] ? 24'hFFFFFF : wsum[23:0]);

	assign diff   = need_s1 - wt_s1;
	assign el_sum = {1'b0, elapsed_q} + {9'd0, step_q};

	always_comb begin
		out_d = '0;
		if (cmd.emit_fire) begin
			out_d.status    = ST_FIRED;
			out_d.out_place = idx_q[3:0];
			out_d.tokens    = tok;
			out_d.wait_time = wnew;
			out_d.step_time = step_q;
			out_d.elapsed   = el_q;
			out_d.last      = sts.last_idx;
		end else begin
			out_d.status = cmd.single_status;
			out_d.last   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			places_q  <= FIELD_CAP;
			trans_q   <= FIELD_CAP;
			clr_q     <= '0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
			vld_s1    <= 1'b0;
			elapsed_q <= '0;
		end else begin
			if (cfg_valid && cfg_index == CFG_PLACES) places_q <= cfg_data;
			if (cfg_valid && cfg_index == CFG_TRANS) trans_q <= cfg_data;
			if (cmd.clr_run) clr_q <= clr_q + WAW'(1);
			if (cmd.start || cmd.idx_zero) idx_q <= '0;
			else if (cmd.adv) idx_q <= idx_q + 5'd1;
			if (cmd.emit_fire || cmd.emit_single) out_vld_q <= 1'b1;
			else if (!result_stall) out_vld_q <= 1'b0;
			vld_s1 <= cmd.scan;
			if (cmd.exec_wr && req_q.operation == OP_WR_ELAPSE)
				elapsed_q <= req_q.elapsed_value;
			else if (cmd.emit_fire && sts.last_idx && req_q.operation == OP_COMMIT)
				elapsed_q <= el_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= request;
			step_q <= '0;
			fail_q <= 1'b0;
		end else begin
			if (cmd.scan && mk < {8'd0, pw}) fail_q <= 1'b1;
			if (vld_s1 && pwnz_s1 && need_s1 > wt_s1 && diff > step_q) step_q <= diff;
		end
		need_s1 <= {8'd0, dl} * {16'd0, pw};
		wt_s1   <= wt;
		pwnz_s1 <= (pw != 8'd0);
		if (cmd.el_calc) el_q <= el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0];
		if (cmd.emit_fire || cmd.emit_single) out_q <= out_d;
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.status != ST_FIRED |-> out_q.last)
		else $error("non-fire result without last");
	a_fire_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fire |-> !fail_q)
		else $error("fire result from a disabled transition");
	a_fire_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fire |-> idx_q < np)
		else $error("fire result beyond active places");
	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fire |=> $stable(step_q))
		else $error("step changed during emit pass");
`endif

endmodule

[rtl/core/timed_petri_net_fire_unit.sv]
// Top level of the timed Petri net fire unit: controller plus datapath.
// Depends on tpnfu_pkg, tpnfu_ctrl, tpnfu_dp (and tpnfu_ram below it).
//
// Usage:
//   request channel (request_valid/request_stall, payload request) takes one
//   operation: weight, delay, place state or elapsed write, fire, or
//   fire_and_commit. result channel (result_valid/result_stall, payload
//   result) returns one result per write or rejected request, and one per
//   active place for a successful fire, last set on the final one.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the active
//   place count (index 0) and transition count (index 1); always ready.
// Order: a write or rejected request has its result registered in S_SINGLE;
//   the next request is accepted only once the controller is back in idle.
//   A fire over N active places scans the place memories for enable check
//   and step, then runs an update/emit pass; the last result is registered
//   before the next request is accepted.
//   A disabled transition answers after the scan, without the update pass.
// Reset: clears config to 16/16, then runs a clearing pass over the net
//   memories; request_stall stays high during that pass.
// Stall: a stalled result holds; the emit pass waits for the output register.
module timed_petri_net_fire_unit
	import tpnfu_pkg::*;
#(
	parameter int MAX_PLACES      = 16,
	parameter int MAX_TRANSITIONS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       request_valid,
	output logic       request_stall,
	input  req_t       request,
	output logic       result_valid,
	input  logic       result_stall,
	output res_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [4:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	tpnfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.request_valid(request_valid), .request_stall(request_stall),
		.sts(sts), .cmd(cmd)
	);

	tpnfu_dp #(
		.MAX_PLACES(MAX_PLACES), .MAX_TRANSITIONS(MAX_TRANSITIONS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .request(request),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result_stall(result_stall),
		.result(result), .cmd(cmd), .sts(sts)
	);

endmodule

[sim/timed_petri_net_fire_unit_tb.sv]
// Testbench for timed_petri_net_fire_unit: directed table plus random firing sequences,
// every result checked against a behavioral net model kept in the bench.
// Depends on tpnfu_pkg and the RTL of the fire unit.
`timescale 1ns / 1ps

module timed_petri_net_fire_unit_tb;
	import tpnfu_pkg::*;

	typedef struct {
		req_t req;
		logic chk;
		res_t res;
	} row_t;

	logic clk, arst_n;
	logic request_valid, request_stall, result_valid, result_stall;
	req_t request;
	res_t result;
	logic cfg_valid, cfg_ready;
	logic [3:0] cfg_index;
	logic [4:0] cfg_data;

	logic [7:0]  pre_w [16][16];
	logic [7:0]  post_w [16][16];
	logic [15:0] delay_m [16];
	logic [15:0] tok_m [16];
	logic [23:0] wait_m [16];
	logic [31:0] elapsed_m;
	logic [4:0]  places_reg, trans_reg;

	res_t expected_q[$];
	int errors, n_req, n_res, n_fired, idle_cnt;
	int snd_idle, rcv_idle;
	bit hold_rx, done;

	timed_petri_net_fire_unit u_dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic res_t single_res(logic [1:0] st);
		res_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic int active(logic [4:0] v);
		if (v == 0) return 1;
		if (v > 16) return 16;
		return int'(v);
	endfunction

	task automatic predict_net(input req_t q);
		int np, nt;
		logic [31:0] step, need, d, t, w;
		logic [32:0] el;
		logic [15:0] nt_tok [16];
		logic [23:0] nt_wait [16];
		res_t r;
		np = active(places_reg);
		nt = active(trans_reg);
		case (q.operation)
			OP_WR_PRE, OP_WR_POST: begin
				if (q.place >= np || q.transition >= nt) begin
					expected_q.push_back(single_res(ST_BAD));
					return;
				end
				if (q.operation == OP_WR_PRE) pre_w[q.place][q.transition] = q.weight;
				else post_w[q.place][q.transition] = q.weight;
				expected_q.push_back(single_res(ST_WRITTEN));
				return;
			end
			OP_WR_DELAY, OP_WR_STATE: begin
				if (q.place >= np) begin
					expected_q.push_back(single_res(ST_BAD));
					return;
				end
				if (q.operation == OP_WR_DELAY) delay_m[q.place] = q.value;
				else begin
					tok_m[q.place] = q.value;
					wait_m[q.place] = q.wait_value;
				end
				expected_q.push_back(single_res(ST_WRITTEN));
				return;
			end
			OP_WR_ELAPSE: begin
				elapsed_m = q.elapsed_value;
				expected_q.push_back(single_res(ST_WRITTEN));
				return;
			end
			OP_FIRE, OP_COMMIT: ;
			default: begin
				expected_q.push_back(single_res(ST_BAD));
				return;
			end
		endcase
		if (q.transition >= nt) begin
			expected_q.push_back(single_res(ST_BAD));
			return;
		end
		for (int i = 0; i < np; i++)
			if (tok_m[i] < pre_w[i][q.transition]) begin
				expected_q.push_back(single_res(ST_NOT_EN));
				return;
			end
		step = 0;
		for (int i = 0; i < np; i++) begin
			need = delay_m[i] * pre_w[i][q.transition];
			if (pre_w[i][q.transition] != 0 && need > wait_m[i]) begin
				d = need - wait_m[i];
				if (d > step) step = d;
			end
		end
		el = elapsed_m + step;
		if (el[32]) el = 33'hFFFFFFFF;
		for (int i = 0; i < np; i++) begin
			t = tok_m[i] - pre_w[i][q.transition] + post_w[i][q.transition];
			if (t > 32'hFFFF) t = 32'hFFFF;
			if (delay_m[i] == 0 || t == 0 || tok_m[i] == 0) w = 0;
			else begin
				w = wait_m[i] + step;
				if (w > 32'hFFFFFF) w = 32'hFFFFFF;
			end
			nt_tok[i] = t[15:0];
			nt_wait[i] = w[23:0];
			r.status = ST_FIRED;
			r.out_place = 4'(i);
			r.tokens = t[15:0];
			r.wait_time = w[23:0];
			r.step_time = step[23:0];
			r.elapsed = el[31:0];
			r.last = (i == np - 1);
			expected_q.push_back(r);
		end
		if (q.operation == OP_COMMIT) begin
			for (int i = 0; i < np; i++) begin
				tok_m[i] = nt_tok[i];
				wait_m[i] = nt_wait[i];
			end
			elapsed_m = el[31:0];
		end
	endtask

	task automatic send_request(input req_t q, input bit chk, input res_t exp_r);
		if (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
			request_valid <= 1'b0;
			@(negedge clk);
			while (snd_idle > 0 && $urandom_range(99) < snd_idle) @(negedge clk);
		end
		request <= q;
		request_valid <= 1'b1;
		@(posedge clk);
		while (request_stall) @(posedge clk);
		if (chk) begin
			predict_net(q);
			if (expected_q[$] != exp_r) begin
				$display("%0t table row mismatch: expected %h actual %h",
					$time, exp_r, expected_q[$]);
				errors++;
			end
		end else predict_net(q);
		n_req++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		request_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [3:0] idx, input logic [4:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_PLACES) places_reg = v;
		else trans_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic req_t rand_req(int np, int nt);
		req_t q;
		int k;
		logic [95:0] rnd;
		rnd = {$urandom, $urandom, $urandom};
		q = rnd[90:0];
		k = $urandom_range(99);
		if (k < 2) q.operation = 3'd7;
		else if (k < 15) q.operation = OP_WR_PRE;
		else if (k < 25) q.operation = OP_WR_POST;
		else if (k < 33) q.operation = OP_WR_DELAY;
		else if (k < 45) q.operation = OP_WR_STATE;
		else if (k < 48) q.operation = OP_WR_ELAPSE;
		else if (k < 70) q.operation = OP_FIRE;
		else q.operation = OP_COMMIT;
		if ($urandom_range(9) != 0) begin
			q.place = 4'($urandom_range(np - 1));
			q.transition = 4'($urandom_range(nt - 1));
		end
		if ($urandom_range(3) != 0) begin
			q.weight = 8'($urandom_range(3));
			q.value = $urandom_range(3) == 0 ? q.value : 16'($urandom_range(20));
			q.wait_value = $urandom_range(3) == 0 ? q.wait_value : 24'($urandom_range(60));
		end
		return q;
	endfunction

	// result side: stall generator and scoreboard
	always @(negedge clk) begin
		if (!arst_n) result_stall <= 1'b0;
		else result_stall <= hold_rx || (rcv_idle > 0 && $urandom_range(99) < rcv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_res++;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $time, result);
				errors++;
			end else begin
				res_t e;
				e = expected_q.pop_front();
				if (e.status == ST_FIRED) n_fired++;
				if (result !== e) begin
					$display("%0t result mismatch: expected %h actual %h", $time, e, result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((request_valid && !request_stall) || (result_valid && !result_stall)) idle_cnt = 0;
		else idle_cnt++;
		if (idle_cnt > 20000 && !done) begin
			$display("%0t watchdog expired", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		row_t tbl[$];
		req_t q;
		res_t z;
		int np, nt;
		arst_n = 0;
		request_valid = 0;
		request = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_rx = 0;
		done = 0;
		snd_idle = 11;
		rcv_idle = 84;
		errors = 0;
		pre_w = '{default: '{default: '0}};
		post_w = '{default: '{default: '0}};
		delay_m = '{default: '0};
		tok_m = '{default: '0};
		wait_m = '{default: '0};
		elapsed_m = '0;
		places_reg = 5'd16;
		trans_reg = 5'd16;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		z = '0;
		// fire on an empty net: every place fires with zero tokens
		q = '0; q.operation = OP_FIRE; tbl.push_back('{q, 0, z});
		q = '0; q.operation = 3'd7; tbl.push_back('{q, 1, single_res(ST_BAD)});
		q = '0; q.operation = OP_WR_ELAPSE; q.elapsed_value = 32'hFFFFFFF0;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_WR_STATE; q.place = 0; q.value = 16'hFFFF;
		q.wait_value = 24'hFFFFFF; tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_WR_DELAY; q.place = 0; q.value = 16'hFFFF;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_WR_PRE; q.place = 0; q.transition = 15; q.weight = 8'hFF;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_WR_POST; q.place = 1; q.transition = 15; q.weight = 8'hFF;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_WR_POST; q.place = 0; q.transition = 15; q.weight = 8'hFF;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_FIRE; q.transition = 15; tbl.push_back('{q, 0, z});
		q = '0; q.operation = OP_COMMIT; q.transition = 15; tbl.push_back('{q, 0, z});
		q = '0; q.operation = OP_COMMIT; q.transition = 15; tbl.push_back('{q, 0, z});
		q = '0; q.operation = OP_WR_STATE; q.place = 0; q.value = 3;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_FIRE; q.transition = 15;
		tbl.push_back('{q, 1, single_res(ST_NOT_EN)});
		q = '0; q.operation = OP_WR_STATE; q.place = 2; q.value = 0; q.wait_value = 5;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_WR_DELAY; q.place = 2; q.value = 7;
		tbl.push_back('{q, 1, single_res(ST_WRITTEN)});
		q = '0; q.operation = OP_COMMIT; q.transition = 3; tbl.push_back('{q, 0, z});
		foreach (tbl[i]) send_request(tbl[i].req, tbl[i].chk, tbl[i].res);
		drain_results();

		write_cfg(CFG_PLACES, 5'd3);
		write_cfg(CFG_TRANS, 5'd2);
		tbl.delete();
		q = '0; q.operation = OP_WR_PRE; q.place = 3; tbl.push_back('{q, 1, single_res(ST_BAD)});
		q = '0; q.operation = OP_WR_POST; q.transition = 2;
		tbl.push_back('{q, 1, single_res(ST_BAD)});
		q = '0; q.operation = OP_WR_DELAY; q.place = 15; tbl.push_back('{q, 1, single_res(ST_BAD)});
		q = '0; q.operation = OP_WR_STATE; q.place = 3; tbl.push_back('{q, 1, single_res(ST_BAD)});
		q = '0; q.operation = OP_FIRE; q.transition = 15; tbl.push_back('{q, 1, single_res(ST_BAD)});
		q = '0; q.operation = OP_COMMIT; q.transition = 1; tbl.push_back('{q, 0, z});
		foreach (tbl[i]) send_request(tbl[i].req, tbl[i].chk, tbl[i].res);
		drain_results();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_cfg(CFG_PLACES, 5'd0); write_cfg(CFG_TRANS, 5'd0); end
				1: begin write_cfg(CFG_PLACES, 5'd31); write_cfg(CFG_TRANS, 5'd31); end
				2: begin
					write_cfg(CFG_PLACES, 5'd4); write_cfg(CFG_TRANS, 5'd3);
					snd_idle = 84; rcv_idle = 11;
				end
				3: begin write_cfg(CFG_PLACES, 5'd16); write_cfg(CFG_TRANS, 5'd16); end
				4: begin
					write_cfg(CFG_PLACES, 5'd2); write_cfg(CFG_TRANS, 5'd5);
					snd_idle = 0; rcv_idle = 0;
				end
				default: begin
					write_cfg(CFG_PLACES, 5'd6); write_cfg(CFG_TRANS, 5'd4);
				end
			endcase
			np = active(places_reg);
			nt = active(trans_reg);
			if (ph == 4) begin
				fork
					begin
						hold_rx = 1;
						repeat (300) @(negedge clk);
						hold_rx = 0;
					end
					for (int k = 0; k < 20; k++)
						send_request(rand_req(np, nt), 0, z);
				join
			end
			for (int k = 0; k < 55; k++) send_request(rand_req(np, nt), 0, z);
			drain_results();
		end

		done = 1;
		$display("Sent %0d requests, checked %0d results (%0d fired places) over",
			n_req, n_res, n_fired);
		$display("writes, rejections, fires and commits at several net sizes.");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
